/* hdl/thc_pkg.sv */
//------------------------------------------------------------------------------
// thc_pkg
// Shared types and constants for the twelve-hour clock with alarm compare.
//------------------------------------------------------------------------------
`default_nettype none

package thc_pkg;

    // Item opcodes; code 3 is unused and only reports the state
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SET  = 2'd1,
        OP_TAP  = 2'd2
    } t_opcode;

    localparam int OPCODE_WIDTH = 2;
    localparam int HOUR_WIDTH   = 4;
    localparam int MINSEC_WIDTH = 6;
    localparam int ALARM_REGS   = 4;
    localparam int ALARM_WIDTH  = 12;
    localparam int TPS_WIDTH    = 10;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = ALARM_WIDTH;

    // Register indexes: alarms occupy 0 .. ALARM_REGS-1
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_TPS = 3'd4;

    localparam logic [TPS_WIDTH-1:0]    TPS_RESET   = 10'd1000;
    localparam logic [HOUR_WIDTH-1:0]   HOUR_LAST   = 4'd12;
    localparam logic [HOUR_WIDTH-1:0]   HOUR_FIRST  = 4'd1;
    localparam logic [HOUR_WIDTH-1:0]   HOUR_PM_FLIP = 4'd11;
    localparam logic [MINSEC_WIDTH-1:0] MINSEC_LAST = 6'd59;

    typedef struct packed {
        logic [HOUR_WIDTH-1:0]   hour;
        logic [MINSEC_WIDTH-1:0] minute;
        logic [MINSEC_WIDTH-1:0] second;
        logic                    pm;
    } t_time;

    // Packed alarm register layout, MSB first
    typedef struct packed {
        logic                    enable;
        logic                    pm;
        logic [MINSEC_WIDTH-1:0] minute;
        logic [HOUR_WIDTH-1:0]   hour;
    } t_alarm;

    typedef struct packed {
        logic                      we;
        logic [CFG_IDX_WIDTH-1:0]  index;
        logic [CFG_DATA_WIDTH-1:0] data;
    } t_cfg_wr;

endpackage : thc_pkg

`default_nettype wire

/* hdl/twelve_hour_clock_with_alarms.sv */
//------------------------------------------------------------------------------
// twelve_hour_clock_with_alarms
// Twelve-hour time of day driven by tick items, with four alarm compares.
//------------------------------------------------------------------------------
// Accepts one item per clock when o_stall is low and returns one result per
// item: the item is captured in an input register, then the counter update,
// alarm compare and ringing flag are done in a single pass into the result
// register, where the clock state commits as well. The result register and
// input register form a two-deep queue, so a new item is taken while a
// finished result waits for the downstream side.
// Registers: index 0-3 alarms (bits 3:0 hour, 9:4 minute, 10 pm, 11 enable),
// index 4 ticks per second. Write them only while the block is idle.
//------------------------------------------------------------------------------
`default_nettype none

module twelve_hour_clock_with_alarms
    import thc_pkg::*;
#(
    parameter int TICK_WIDTH  = 10,
    parameter int ALARM_COUNT = 4
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0] i_cfg_data,
    // item in
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [OPCODE_WIDTH-1:0]   i_opcode,
    input  wire logic [HOUR_WIDTH-1:0]     i_set_hour,
    input  wire logic [MINSEC_WIDTH-1:0]   i_set_minute,
    input  wire logic [MINSEC_WIDTH-1:0]   i_set_second,
    input  wire logic                      i_set_pm,
    input  wire logic                      i_tap_stop_mode,
    // result out
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [HOUR_WIDTH-1:0]          o_hours,
    output logic [MINSEC_WIDTH-1:0]        o_minutes,
    output logic [MINSEC_WIDTH-1:0]        o_seconds,
    output logic                           o_is_pm,
    output logic                           o_ringing,
    output logic [ALARM_REGS-1:0]          o_match_mask
);

    t_cfg_wr cfg;

    logic                    r_in_valid;
    logic [OPCODE_WIDTH-1:0] r_opcode;
    logic [HOUR_WIDTH-1:0]   r_set_hour;
    logic [MINSEC_WIDTH-1:0] r_set_minute;
    logic [MINSEC_WIDTH-1:0] r_set_second;
    logic                    r_set_pm;
    logic                    r_tap_stop_mode;

    logic                    r_out_valid;
    t_time                   r_out_time;
    logic [ALARM_REGS-1:0]   r_out_mask;
    logic                    r_ring, n_ring;

    logic                    out_free;
    logic                    adv;
    logic                    in_accept;
    t_time                   next_time;
    logic [ALARM_REGS-1:0]   next_mask;

    assign cfg = '{we: i_cfg_we, index: i_cfg_index, data: i_cfg_data};

    assign out_free  = !r_out_valid || !i_stall;
    assign adv       = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    thc_timekeeper #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_timekeeper (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_adv        (adv),
        .i_op         (r_opcode),
        .i_set_hour   (r_set_hour),
        .i_set_minute (r_set_minute),
        .i_set_second (r_set_second),
        .i_set_pm     (r_set_pm),
        .o_next       (next_time)
    );

    thc_alarm_match #(
        .ALARM_COUNT (ALARM_COUNT)
    ) u_alarm_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_time  (next_time),
        .o_mask  (next_mask)
    );

    // ringing is raised only by ticks; a tap clears it only in tap-stop mode
    always_comb begin
        n_ring = r_ring;
        if ((r_opcode == OP_TICK) && (|next_mask)) begin
            n_ring = 1'b1;
        end else if ((r_opcode == OP_TAP) && r_tap_stop_mode) begin
            n_ring = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ring      <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_ring      <= n_ring;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_opcode        <= i_opcode;
            r_set_hour      <= i_set_hour;
            r_set_minute    <= i_set_minute;
            r_set_second    <= i_set_second;
            r_set_pm        <= i_set_pm;
            r_tap_stop_mode <= i_tap_stop_mode;
        end
        if (adv) begin
            r_out_time <= next_time;
            r_out_mask <= next_mask;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hours      = r_out_time.hour;
    assign o_minutes    = r_out_time.minute;
    assign o_seconds    = r_out_time.second;
    assign o_is_pm      = r_out_time.pm;
    assign o_ringing    = r_ring;
    assign o_match_mask = r_out_mask;

endmodule : twelve_hour_clock_with_alarms

`default_nettype wire

/* hdl/thc_timekeeper.sv */
//------------------------------------------------------------------------------
// thc_timekeeper
// Tick divider and hour/minute/second/AM-PM counters. Presents the time that
// results from the current item; the state commits when the item advances.
//------------------------------------------------------------------------------
`default_nettype none

module thc_timekeeper
    import thc_pkg::*;
#(
    parameter int TICK_WIDTH = 10
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cfg_wr                 i_cfg,
    input  wire logic                    i_adv,
    input  wire logic [OPCODE_WIDTH-1:0] i_op,
    input  wire logic [HOUR_WIDTH-1:0]   i_set_hour,
    input  wire logic [MINSEC_WIDTH-1:0] i_set_minute,
    input  wire logic [MINSEC_WIDTH-1:0] i_set_second,
    input  wire logic                    i_set_pm,
    output t_time                        o_next
);

    localparam int CMP_W = (TICK_WIDTH > TPS_WIDTH) ? TICK_WIDTH : TPS_WIDTH;

    logic [TICK_WIDTH-1:0] r_tick, n_tick;
    logic [TPS_WIDTH-1:0]  r_tps;
    t_time                 r_time, n_time;

    logic [TICK_WIDTH-1:0] tick_inc;
    logic                  tick_roll;
    logic                  sec_carry;
    logic                  min_carry;

    always_comb begin
        tick_inc  = r_tick + 1'b1;
        // counter saturation also rolls, so a lowered divisor recovers
        tick_roll = (r_tick == '1) || (CMP_W'(tick_inc) >= CMP_W'(r_tps));
        sec_carry = tick_roll && (r_time.second == MINSEC_LAST);
        min_carry = sec_carry && (r_time.minute == MINSEC_LAST);

        n_tick = r_tick;
        n_time = r_time;
        unique case (i_op)
            OP_TICK: begin
                n_tick = tick_roll ? '0 : tick_inc;
                if (tick_roll) begin
                    n_time.second = sec_carry ? '0 : r_time.second + 1'b1;
                end
                if (sec_carry) begin
                    n_time.minute = min_carry ? '0 : r_time.minute + 1'b1;
                end
                if (min_carry) begin
                    if (r_time.hour == HOUR_PM_FLIP) begin
                        n_time.pm = ~r_time.pm;
                    end
                    n_time.hour = (r_time.hour >= HOUR_LAST) ? HOUR_FIRST
                                                             : r_time.hour + 1'b1;
                end
            end
            OP_SET: begin
                n_tick = '0;
                n_time.hour = ((i_set_hour == '0) || (i_set_hour > HOUR_LAST))
                            ? HOUR_LAST : i_set_hour;
                n_time.minute = (i_set_minute > MINSEC_LAST) ? MINSEC_LAST
                                                             : i_set_minute;
                n_time.second = (i_set_second > MINSEC_LAST) ? MINSEC_LAST
                                                             : i_set_second;
                n_time.pm = i_set_pm;
            end
            default: begin
                // tap and unused code leave the time alone
            end
        endcase
    end

    assign o_next = n_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick        <= '0;
            r_tps         <= TPS_RESET;
            r_time.hour   <= HOUR_LAST;
            r_time.minute <= '0;
            r_time.second <= '0;
            r_time.pm     <= 1'b0;
        end else begin
            if (i_cfg.we && (i_cfg.index == CFG_TPS)) begin
                r_tps <= i_cfg.data[TPS_WIDTH-1:0];
            end
            if (i_adv) begin
                r_tick <= n_tick;
                r_time <= n_time;
            end
        end
    end

endmodule : thc_timekeeper

`default_nettype wire

/* hdl/thc_alarm_match.sv */
//------------------------------------------------------------------------------
// thc_alarm_match
// Alarm registers and per-alarm compare of hour, minute and half-day.
//------------------------------------------------------------------------------
`default_nettype none

module thc_alarm_match
    import thc_pkg::*;
#(
    parameter int ALARM_COUNT = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg_wr               i_cfg,
    input  wire t_time                 i_time,
    output logic [ALARM_REGS-1:0]      o_mask
);

    t_alarm r_alarm [ALARM_REGS];

    always_comb begin
        for (int i = 0; i < ALARM_REGS; i++) begin
            // seconds are not compared
            o_mask[i] = (i < ALARM_COUNT) && r_alarm[i].enable
                     && (r_alarm[i].hour   == i_time.hour)
                     && (r_alarm[i].minute == i_time.minute)
                     && (r_alarm[i].pm     == i_time.pm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ALARM_REGS; i++) begin
                r_alarm[i] <= '0;
            end
        end else if (i_cfg.we && (32'(i_cfg.index) < ALARM_REGS)) begin
            r_alarm[i_cfg.index[1:0]] <= t_alarm'(i_cfg.data);
        end
    end

endmodule : thc_alarm_match

`default_nettype wire
